/* src/sll_pkg.sv */
// Shared types and codes for the sorted linked list engine.
package sll_pkg;

   localparam int VALUE_W = 32;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_DUMP   = 2'd2;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_FULL     = 2'd1;
   localparam logic [1:0] STATUS_NOTFOUND = 2'd2;
   localparam logic [1:0] STATUS_EMPTY    = 2'd3;

   typedef enum logic [2:0] {
      CELL_HOLD    = 3'd0,
      CELL_COMPARE = 3'd1,
      CELL_INSERT  = 3'd2,
      CELL_REMOVE  = 3'd3,
      CELL_ROTATE  = 3'd4
   } cell_op_type;

   // what a cell shows its neighbors
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      valid;
      logic                      lt;
   } cell_link_type;

endpackage

/* src/sll_cell.sv */
// One list cell: holds one element, its compare flags, and shifts with its neighbors.
module sll_cell
   import sll_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  cell_op_type               op,
   input  logic signed [VALUE_W-1:0] key,
   input  cell_link_type             left_link,
   input  cell_link_type             right_link,
   output cell_link_type             link,
   output logic                      eq
);

   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic                      valid_ff, valid_in;
   logic                      lt_ff, lt_in;
   logic                      eq_ff, eq_in;

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      lt_in    = lt_ff;
      eq_in    = eq_ff;
      unique case (op)
         CELL_COMPARE: begin
            lt_in = valid_ff && (value_ff < key);
            eq_in = valid_ff && (value_ff == key);
         end
         CELL_INSERT: begin
            if (!lt_ff) begin
               value_in = left_link.lt ? key : left_link.value;
               valid_in = left_link.valid;
            end
         end
         CELL_REMOVE: begin
            if (valid_ff && !lt_ff) begin
               value_in = right_link.value;
               valid_in = right_link.valid;
            end
         end
         CELL_ROTATE: begin
            value_in = right_link.value;
            valid_in = right_link.valid;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         lt_ff    <= 1'b0;
         eq_ff    <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         lt_ff    <= lt_in;
         eq_ff    <= eq_in;
      end
      value_ff <= value_in;
   end

   assign link.value = value_ff;
   assign link.valid = valid_ff;
   assign link.lt    = lt_ff;
   assign eq         = eq_ff;

endmodule

/* src/sorted_linked_list_engine.sv */
// Top level: sorted list of signed words kept in a row of shifting cells.
//
//  channel  ports                                   handshake
//  request  req_command, req_value                  start & !busy
//  result   rsp_out_value, rsp_status, rsp_last     rsp_strobe, one cycle
//
// Insert and remove go through accept, compare in every cell, then shift (a remove shifts only if found).
// Dump rotates the row once around, one element per cycle.
// Refused inserts, dumps of an empty list and unused commands are answered without leaving idle.
// Reset empties the list. A result is registered and shows in the cycle after the deciding cycle;
// the receiver cannot stall, so results never back up.
module sorted_linked_list_engine
   import sll_pkg::*;
#(
   parameter int SLOTS = 16
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [1:0]                req_command,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_strobe,
   output logic signed [VALUE_W-1:0] rsp_out_value,
   output logic [1:0]                rsp_status,
   output logic                      rsp_last
);

   localparam int CNT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SLOTS - 1);

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_COMPARE = 4'b0010,
      ST_APPLY   = 4'b0100,
      ST_DUMP    = 4'b1000
   } state_type;

   state_type                 state_ff, state_in;
   logic [1:0]                cmd_ff, cmd_in;
   logic signed [VALUE_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0]          count_ff, count_in;

   logic                      rsp_strobe_ff, rsp_strobe_in;
   logic signed [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [1:0]                rsp_status_ff, rsp_status_in;
   logic                      rsp_last_ff, rsp_last_in;

   cell_op_type   cell_op;
   cell_link_type links [SLOTS];
   cell_link_type left_links [SLOTS];
   cell_link_type right_links [SLOTS];
   logic [SLOTS-1:0] eq_flags;
   logic             found;
   logic             accept;

   assign busy   = !state_ff[0];
   assign accept = start && !busy;
   assign found  = |eq_flags;

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         if (i == 0) begin
            left_links[i].value = '0;
            left_links[i].valid = 1'b1;
            left_links[i].lt    = 1'b1;
         end else begin
            left_links[i] = links[i-1];
         end
         if (i == SLOTS - 1) begin
            if (cell_op == CELL_ROTATE) begin
               right_links[i] = links[0];
            end else begin
               right_links[i] = '0;
            end
         end else begin
            right_links[i] = links[i+1];
         end
      end
   end

   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      sll_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .op         (cell_op),
         .key        (key_ff),
         .left_link  (left_links[g]),
         .right_link (right_links[g]),
         .link       (links[g]),
         .eq         (eq_flags[g])
      );
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      count_in      = count_ff;
      cell_op       = CELL_HOLD;
      rsp_strobe_in = 1'b0;
      rsp_value_in  = '0;
      rsp_status_in = STATUS_OK;
      rsp_last_in   = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in   = req_command;
               key_in   = req_value;
               count_in = '0;
               priority if (req_command == CMD_INSERT && links[SLOTS-1].valid) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = STATUS_FULL;
               end else if (req_command == CMD_INSERT || req_command == CMD_REMOVE) begin
                  state_in = ST_COMPARE;
               end else if (req_command == CMD_DUMP && !links[0].valid) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = STATUS_EMPTY;
               end else if (req_command == CMD_DUMP) begin
                  state_in = ST_DUMP;
               end else begin
                  rsp_strobe_in = 1'b1;
               end
            end
         end
         ST_COMPARE: begin
            cell_op  = CELL_COMPARE;
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
            if (cmd_ff == CMD_INSERT) begin
               cell_op = CELL_INSERT;
            end else if (found) begin
               cell_op = CELL_REMOVE;
            end else begin
               rsp_status_in = STATUS_NOTFOUND;
            end
         end
         ST_DUMP: begin
            cell_op       = CELL_ROTATE;
            rsp_strobe_in = links[0].valid;
            rsp_value_in  = links[0].value;
            rsp_last_in   = (count_ff == CNT_LAST) || !links[1].valid;
            count_in      = count_ff + 1'b1;
            if (count_ff == CNT_LAST) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      count_ff      <= count_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

/* sim/tb_sorted_linked_list_engine.sv */
// Self-checking testbench for the sorted linked list engine: random and directed commands.

typedef struct {
   logic signed [31:0] value;
   logic [1:0]         status;
   logic               last;
} list_result_type;

class list_scoreboard #(int DEPTH = 16);
   logic signed [31:0] contents[$];
   list_result_type    expected[$];
   int                 errors;
   int                 results_seen;
   int                 dumps;
   int                 full_refusals;
   int                 misses;

   function void push_result(logic signed [31:0] v, logic [1:0] st, logic lst);
      list_result_type r;
      r.value  = v;
      r.status = st;
      r.last   = lst;
      expected.push_back(r);
   endfunction

   // sorted queue: insert ahead of the first element not smaller
   function void note_word(logic [1:0] cmd, logic signed [31:0] v);
      int idx;
      idx = 0;
      case (cmd)
         sll_pkg::CMD_INSERT: begin
            if (contents.size() >= DEPTH) begin
               full_refusals++;
               push_result(0, sll_pkg::STATUS_FULL, 1'b1);
            end else begin
               while (idx < contents.size() && contents[idx] < v) idx++;
               contents.insert(idx, v);
               push_result(0, sll_pkg::STATUS_OK, 1'b1);
            end
         end
         sll_pkg::CMD_REMOVE: begin
            while (idx < contents.size() && contents[idx] != v) idx++;
            if (idx < contents.size()) begin
               contents.delete(idx);
               push_result(0, sll_pkg::STATUS_OK, 1'b1);
            end else begin
               misses++;
               push_result(0, sll_pkg::STATUS_NOTFOUND, 1'b1);
            end
         end
         sll_pkg::CMD_DUMP: begin
            dumps++;
            if (contents.size() == 0) begin
               push_result(0, sll_pkg::STATUS_EMPTY, 1'b1);
            end else begin
               foreach (contents[i])
                  push_result(contents[i], sll_pkg::STATUS_OK, i == contents.size() - 1);
            end
         end
         default: begin
            push_result(0, sll_pkg::STATUS_OK, 1'b1);
         end
      endcase
   endfunction

   function void check_word(logic signed [31:0] v, logic [1:0] st, logic lst);
      list_result_type want;
      results_seen++;
      if (expected.size() == 0) begin
         errors++;
         $error("unexpected result word: out_value %0d status %0d last %0d", v, st, lst);
         return;
      end
      want = expected.pop_front();
      if (v !== want.value) begin
         errors++;
         $error("out_value: expected %0d, got %0d", want.value, v);
      end
      if (st !== want.status) begin
         errors++;
         $error("status: expected %0d, got %0d", want.status, st);
      end
      if (lst !== want.last) begin
         errors++;
         $error("last: expected %0d, got %0d", want.last, lst);
      end
   endfunction
endclass

module tb_sorted_linked_list_engine;
   import sll_pkg::*;

   localparam int         LIST_SLOTS   = 16;
   localparam int         RANDOM_WORDS = 310;
   localparam int         CALM_TAIL    = 60;
   localparam int         CYCLE_LIMIT  = 200000;
   localparam logic [1:0] CMD_UNUSED   = 2'd3;
   localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] VALUE_MAX = 32'sh7FFF_FFFF;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic [1:0]                req_command = CMD_INSERT;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      rsp_strobe;
   logic signed [VALUE_W-1:0] rsp_out_value;
   logic [1:0]                rsp_status;
   logic                      rsp_last;

   list_scoreboard #(LIST_SLOTS) sb;
   int cycles = 0;
   int words_sent = 0;

   sorted_linked_list_engine #(.SLOTS(LIST_SLOTS)) u_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_command   (req_command),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_out_value (rsp_out_value),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("** sorted_linked_list_engine: FAILED **");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         sb.check_word(rsp_out_value, rsp_status, rsp_last);
   end

   task automatic send_word(logic [1:0] cmd, logic signed [31:0] v);
      start       <= 1'b1;
      req_command <= cmd;
      req_value   <= v;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_word(cmd, v);
      words_sent++;
   endtask

   task automatic pause_sender(int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic wait_drain();
      start <= 1'b0;
      while (sb.expected.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 3))
         0, 1:    return int'($urandom_range(0, 8)) - 4;
         2:       return $urandom;
         default: return $urandom_range(0, 1) ? VALUE_MIN + int'($urandom_range(0, 2))
                                              : VALUE_MAX - int'($urandom_range(0, 2));
      endcase
   endfunction

   initial begin
      logic [1:0]         cmd;
      logic signed [31:0] v;
      bit                 growing;
      bit                 idling;
      int                 roll;

      sb = new();
      growing = 1'b1;
      idling  = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: empty list, extremes, duplicates, misses, unused code
      send_word(CMD_DUMP, 32'sd7);
      send_word(CMD_REMOVE, 32'sd0);
      send_word(CMD_UNUSED, -32'sd1);
      send_word(CMD_INSERT, 32'sd0);
      send_word(CMD_INSERT, VALUE_MAX);
      send_word(CMD_INSERT, VALUE_MIN);
      send_word(CMD_INSERT, -32'sd1);
      send_word(CMD_INSERT, -32'sd1);
      send_word(CMD_INSERT, 32'sd1);
      send_word(CMD_INSERT, VALUE_MIN);
      send_word(CMD_DUMP, -32'sd1);
      send_word(CMD_REMOVE, -32'sd1);
      send_word(CMD_REMOVE, 32'sd12345);
      send_word(CMD_REMOVE, VALUE_MAX);
      send_word(CMD_UNUSED, 32'sd0);
      send_word(CMD_DUMP, 32'sd0);
      send_word(CMD_REMOVE, VALUE_MIN);
      send_word(CMD_REMOVE, VALUE_MIN);
      send_word(CMD_REMOVE, 32'sd0);
      send_word(CMD_REMOVE, -32'sd1);
      send_word(CMD_REMOVE, 32'sd1);
      send_word(CMD_DUMP, VALUE_MIN);
      wait_drain();

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n == RANDOM_WORDS / 2)
            wait_drain();
         if (n % 40 == 0)
            idling = $urandom_range(0, 2) != 0;
         if (idling && n < RANDOM_WORDS - CALM_TAIL && $urandom_range(0, 2) == 0)
            pause_sender($urandom_range(1, 16));

         // alternate between filling up and draining the list
         if (growing && sb.contents.size() == LIST_SLOTS && $urandom_range(0, 3) == 0)
            growing = 1'b0;
         else if (!growing && sb.contents.size() == 0 && $urandom_range(0, 2) == 0)
            growing = 1'b1;
         else if ($urandom_range(0, 49) == 0)
            growing = !growing;

         roll = $urandom_range(0, 99);
         v = pick_value();
         if (roll < 3)
            cmd = CMD_UNUSED;
         else if (roll < 13)
            cmd = CMD_DUMP;
         else if (roll < (growing ? 80 : 35))
            cmd = CMD_INSERT;
         else begin
            cmd = CMD_REMOVE;
            if (sb.contents.size() != 0 && $urandom_range(0, 3) != 0)
               v = sb.contents[$urandom_range(0, sb.contents.size() - 1)];
         end
         send_word(cmd, v);
      end

      wait_drain();
      repeat (LIST_SLOTS + 4) @(posedge clock);

      $display("%0d command words sent, %0d result words checked", words_sent,
               sb.results_seen);
      $display("%0d dumps, %0d refused inserts on a full list, %0d removes of absent values",
               sb.dumps, sb.full_refusals, sb.misses);
      if (sb.errors == 0 && sb.expected.size() == 0) begin
         $display("** sorted_linked_list_engine: PASSED **");
      end else begin
         $display("** sorted_linked_list_engine: FAILED **");
      end
      $finish;
   end

endmodule
